// ----- src/cfr_pkg.sv -----
// Shared types and constants of the command frame receiver.
package cfr_pkg;

  // Payload bytes stored per list-init frame before the frame is dropped.
  localparam int unsigned MaxPayload = 32;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UserW   = 16;
  localparam int unsigned EventW  = 2;
  localparam int unsigned PidxW   = 5;
  localparam int unsigned PcountW = 6;
  localparam int unsigned CfgIdxW = 3;

  // Event codes on the result channel.
  localparam logic [EventW-1:0] EvInProgress = 2'd0;
  localparam logic [EventW-1:0] EvComplete   = 2'd1;
  localparam logic [EventW-1:0] EvDropped    = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStartCode      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeAuth       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCodeListInit   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCodeSecReply   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCodeModReply   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [ByteW-1:0] RstStartCode    = 8'd126;
  localparam logic [ByteW-1:0] RstCodeAuth     = 8'd1;
  localparam logic [ByteW-1:0] RstCodeListInit = 8'd2;
  localparam logic [ByteW-1:0] RstCodeSecReply = 8'd3;
  localparam logic [ByteW-1:0] RstCodeModReply = 8'd4;

  // One-based byte positions within a frame.
  localparam logic [ByteW-1:0] PosStart   = 8'd1;
  localparam logic [ByteW-1:0] PosLength  = 8'd2;
  localparam logic [ByteW-1:0] PosCommand = 8'd3;
  localparam logic [ByteW-1:0] PosAuth    = 8'd4;
  localparam logic [ByteW-1:0] PosUserHi  = 8'd5;
  localparam logic [ByteW-1:0] PosUserLo  = 8'd6;
  localparam logic [ByteW-1:0] PosCount   = 8'd7;

  // Current configuration as seen by the parser.
  typedef struct packed {
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] code_auth;
    logic [ByteW-1:0] code_list_init;
    logic [ByteW-1:0] code_security_reply;
    logic [ByteW-1:0] code_modify_reply;
  } cfr_cfg_t;

  // One result item.
  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic              payload_valid;
    logic [ByteW-1:0]  payload_byte;
    logic [PidxW-1:0]  payload_index;
    logic [ByteW-1:0]  frame_command;
    logic [ByteW-1:0]  auth_level;
    logic [UserW-1:0]  user_number;
    logic [ByteW-1:0]  book_total;
    logic [ByteW-1:0]  checked_out;
    logic [ByteW-1:0]  book_state;
  } cfr_result_t;

endpackage

// ----- src/cfr_if.sv -----
// Channel interfaces of the command frame receiver: bytes in, results out, configuration.
interface cfr_byte_if import cfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_result_if import cfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_res;
  logic              payload_valid;
  logic [ByteW-1:0]  payload_byte;
  logic [PidxW-1:0]  payload_index;
  logic [ByteW-1:0]  frame_command;
  logic [ByteW-1:0]  auth_level;
  logic [UserW-1:0]  user_number;
  logic [ByteW-1:0]  book_total;
  logic [ByteW-1:0]  checked_out;
  logic [ByteW-1:0]  book_state;

  modport source (output valid, output event_res, output payload_valid,
                  output payload_byte, output payload_index, output frame_command,
                  output auth_level, output user_number, output book_total,
                  output checked_out, output book_state, input ready);
  modport sink   (input valid, input event_res, input payload_valid,
                  input payload_byte, input payload_index, input frame_command,
                  input auth_level, input user_number, input book_total,
                  input checked_out, input book_state, output ready);
endinterface

interface cfr_cfg_if import cfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/cfr_cfg_regs.sv -----
// Configuration registers: start code and the four command codes.
module cfr_cfg_regs import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [ByteW-1:0]   wr_data,
  output cfr_cfg_t           cfg
);

  cfr_cfg_t regs;

  // Write decode; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_code          <= RstStartCode;
      regs.code_auth           <= RstCodeAuth;
      regs.code_list_init      <= RstCodeListInit;
      regs.code_security_reply <= RstCodeSecReply;
      regs.code_modify_reply   <= RstCodeModReply;
    end else if (wr_en) begin
      unique case (wr_index)
        CfgStartCode:    regs.start_code          <= wr_data;
        CfgCodeAuth:     regs.code_auth           <= wr_data;
        CfgCodeListInit: regs.code_list_init      <= wr_data;
        CfgCodeSecReply: regs.code_security_reply <= wr_data;
        CfgCodeModReply: regs.code_modify_reply   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- src/cfr_parser.sv -----
// Frame parser: holds the frame state and computes the result for each accepted byte.
module cfr_parser import cfr_pkg::*; #(
  parameter int unsigned PayloadMax = MaxPayload
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [ByteW-1:0] rx_byte,
  input  cfr_cfg_t         cfg,
  output cfr_result_t      result
);

  // Payload bound as an 8-bit value for the compare against the count.
  localparam logic [ByteW-1:0] PayloadMaxB = ByteW'(PayloadMax);

  logic [ByteW-1:0]   byte_position, byte_position_next;
  logic [ByteW-1:0]   frame_length, frame_length_next;
  logic [ByteW-1:0]   current_command, current_command_next;
  logic [PcountW-1:0] payload_count, payload_count_next;
  logic [ByteW-1:0]   auth_reg, auth_reg_next;
  logic [UserW-1:0]   user_reg, user_reg_next;
  logic [ByteW-1:0]   count_reg, count_reg_next;
  logic [ByteW-1:0]   checkout_reg, checkout_reg_next;
  logic [ByteW-1:0]   status_reg, status_reg_next;

  logic [ByteW-1:0] pos;
  logic             drop;
  logic             fill;
  logic             stored;
  logic             done;
  logic [PidxW-1:0] store_index;

  // Decode of one byte against the frame state.
  always_comb begin
    pos                  = byte_position + 8'd1;
    drop                 = 1'b0;
    fill                 = 1'b0;
    stored               = 1'b0;
    store_index          = '0;
    byte_position_next   = pos;
    frame_length_next    = frame_length;
    current_command_next = current_command;
    payload_count_next   = payload_count;
    auth_reg_next        = auth_reg;
    user_reg_next        = user_reg;
    count_reg_next       = count_reg;
    checkout_reg_next    = checkout_reg;
    status_reg_next      = status_reg;

    if (pos == PosStart) begin
      drop = (rx_byte != cfg.start_code);
    end else if (pos == PosLength) begin
      frame_length_next = rx_byte;
    end else if (pos == PosCommand) begin
      current_command_next = rx_byte;
    end else if (current_command == cfg.code_auth) begin
      if (pos == PosAuth) auth_reg_next = rx_byte;
      else if (pos == PosUserHi) user_reg_next[UserW-1:ByteW] = rx_byte;
      else if (pos == PosUserLo) user_reg_next[ByteW-1:0] = rx_byte;
      else drop = 1'b1;
    end else if (current_command == cfg.code_list_init) begin
      if (pos == PosAuth) auth_reg_next = rx_byte;
      else if (pos == PosUserHi) user_reg_next[UserW-1:ByteW] = rx_byte;
      else if (pos == PosUserLo) user_reg_next[ByteW-1:0] = rx_byte;
      else if (pos == PosCount) count_reg_next = rx_byte;
      else fill = 1'b1;
    end else if (current_command == cfg.code_security_reply) begin
      checkout_reg_next = rx_byte;
    end else if (current_command == cfg.code_modify_reply) begin
      status_reg_next = rx_byte;
    end else begin
      drop = 1'b1;
    end

    // Payload store while there is room, otherwise the frame overflows.
    if (fill) begin
      if (ByteW'(payload_count) < PayloadMaxB) begin
        stored             = 1'b1;
        store_index        = payload_count[PidxW-1:0];
        payload_count_next = payload_count + 6'd1;
      end else begin
        drop = 1'b1;
      end
    end

    // Body longer than the announced length.
    if (pos > PosCommand && pos > frame_length) drop = 1'b1;

    // Completion compares with the length as it stands after this byte.
    done = (pos == frame_length_next);
    if (done || drop) begin
      byte_position_next = '0;
      payload_count_next = '0;
    end
    if (drop) stored = 1'b0;
  end

  // Frame state; advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      frame_length    <= '0;
      current_command <= '0;
      payload_count   <= '0;
      auth_reg        <= '0;
      user_reg        <= '0;
      count_reg       <= '0;
      checkout_reg    <= '0;
      status_reg      <= '0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      frame_length    <= frame_length_next;
      current_command <= current_command_next;
      payload_count   <= payload_count_next;
      auth_reg        <= auth_reg_next;
      user_reg        <= user_reg_next;
      count_reg       <= count_reg_next;
      checkout_reg    <= checkout_reg_next;
      status_reg      <= status_reg_next;
    end
  end

  // Result item for this byte.
  always_comb begin
    result.event_res     = drop ? EvDropped : (done ? EvComplete : EvInProgress);
    result.payload_valid = stored;
    result.payload_byte  = stored ? rx_byte : '0;
    result.payload_index = stored ? store_index : '0;
    result.frame_command = current_command_next;
    result.auth_level    = auth_reg_next;
    result.user_number   = user_reg_next;
    result.book_total    = count_reg_next;
    result.checked_out   = checkout_reg_next;
    result.book_state    = status_reg_next;
  end

endmodule

// ----- src/cfr_out_stage.sv -----
// Result register that holds one result until the consumer takes it.
module cfr_out_stage import cfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  cfr_result_t din,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        can_load,
  output cfr_result_t dout
);

  logic        valid;
  cfr_result_t data;

  // The stage takes a new result when empty or when its result leaves this cycle.
  assign can_load = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= din;
    end
  end

  assign out_valid = valid;
  assign dout      = data;

endmodule

// ----- src/command_frame_receiver_core.sv -----
// Top level of the command frame receiver.
//
//   channel  dir  payload                                    transfer when
//   rx       in   rx_byte                                    rx.valid && rx.ready
//   res      out  event_res, payload fields, latched values  res.valid && res.ready
//   cfg      in   index (0..4), data                         cfg.valid (ready is high)
//
// Each received byte is decoded combinationally and its result appears in the
// result register on the next cycle; one byte can be taken every cycle.
// rx.ready is low only while a result sits in the result register and the
// consumer is not taking it. Reset (synchronous, active high) clears the frame
// state, loads the default codes and empties the result register.
module command_frame_receiver_core import cfr_pkg::*; #(
  parameter int unsigned PayloadMax = MaxPayload
) (
  input logic                clk,
  input logic                rst,
  cfr_byte_if.sink           rx,
  cfr_result_if.source       res,
  cfr_cfg_if.sink            cfg
);

  cfr_cfg_t    cfg_regs;
  cfr_result_t parse_result;
  cfr_result_t out_result;
  logic        can_load;
  logic        rx_xfer;

  assign cfg.ready = 1'b1;
  assign rx.ready  = can_load;
  assign rx_xfer   = rx.valid && can_load;

  cfr_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  cfr_parser #(
    .PayloadMax (PayloadMax)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (rx_xfer),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg_regs),
    .result  (parse_result)
  );

  cfr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (rx_xfer),
    .din       (parse_result),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .can_load  (can_load),
    .dout      (out_result)
  );

  // Result fields onto the output channel.
  assign res.event_res     = out_result.event_res;
  assign res.payload_valid = out_result.payload_valid;
  assign res.payload_byte  = out_result.payload_byte;
  assign res.payload_index = out_result.payload_index;
  assign res.frame_command = out_result.frame_command;
  assign res.auth_level    = out_result.auth_level;
  assign res.user_number   = out_result.user_number;
  assign res.book_total    = out_result.book_total;
  assign res.checked_out   = out_result.checked_out;
  assign res.book_state    = out_result.book_state;

endmodule

// ----- src/cfr_checker.sv -----
// Port-level checks of the command frame receiver and their binding.
module cfr_checker import cfr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [EventW-1:0] event_res,
  input logic              payload_valid,
  input logic [ByteW-1:0]  payload_byte,
  input logic [PidxW-1:0]  payload_index
);

  // Every transfer in produces a result on the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte did not produce a result");

  // A stored payload byte never belongs to a dropped frame.
  a_payload_not_dropped: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> event_res != EvDropped)
    else $error("payload reported on a dropped byte");

  // Payload fields read zero when nothing was stored.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> payload_byte == '0 && payload_index == '0)
    else $error("payload fields not cleared");

  // The event code is one of the three defined codes.
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res == EvInProgress || event_res == EvComplete
               || event_res == EvDropped)
    else $error("undefined event code");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res)
                               && $stable(payload_byte))
    else $error("stalled result changed");

endmodule

bind command_frame_receiver_core cfr_checker u_cfr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (rx.valid),
  .in_ready      (rx.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .event_res     (res.event_res),
  .payload_valid (res.payload_valid),
  .payload_byte  (res.payload_byte),
  .payload_index (res.payload_index)
);
